// ===== design/bcs_pkg.sv =====
// Shared types for the Bezout coefficient solver.
// Holds the controller state encoding and the command and status bundles.
// No dependencies.
package bcs_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EVAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic zero_op;
        logic div_last;
        logic rem_zero;
    } status_t;

endpackage

// ===== design/bezout_coefficient_solver.sv =====
// Top level of the Bezout coefficient solver (extended Euclidean algorithm).
// Joins bcs_ctrl and bcs_datapath; depends on bcs_pkg.
//
//   channel   handshake            payload
//   input     start & !busy        operand_a, operand_b
//   result    done (one cycle)     coeff_x, coeff_y, divisor, zero_error
//
// A transaction's run time is set by the number of remainder updates and by
// the bit-serial divider, one quotient bit per cycle with the coefficient
// products accumulated alongside; a zero operand skips the divider.
// busy stays high through done.
// Reset returns the controller to idle; the receiver cannot stall results.
module bezout_coefficient_solver
    import bcs_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [WIDTH-2:0]        operand_a,
    input  logic [WIDTH-2:0]        operand_b,
    output logic                    done,
    output logic signed [WIDTH-1:0] coeff_x,
    output logic signed [WIDTH-1:0] coeff_y,
    output logic [WIDTH-2:0]        divisor,
    output logic                    zero_error
);

    cmd_t    cmd;
    status_t status;

    bcs_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    bcs_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .coeff_x    (coeff_x),
        .coeff_y    (coeff_y),
        .divisor    (divisor),
        .zero_error (zero_error)
    );

endmodule

// ===== design/bcs_datapath.sv =====
// Datapath of the Bezout coefficient solver: remainder and coefficient registers,
// bit-serial restoring divider with fused shift-add quotient multiplication.
// Depends on bcs_pkg.
module bcs_datapath
    import bcs_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic [WIDTH-2:0]        operand_a,
    input  logic [WIDTH-2:0]        operand_b,
    output logic signed [WIDTH-1:0] coeff_x,
    output logic signed [WIDTH-1:0] coeff_y,
    output logic [WIDTH-2:0]        divisor,
    output logic                    zero_error
);

    localparam int DIV_STEPS = WIDTH - 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic [WIDTH-2:0] r_prev_reg, r_cur_reg, div_rem_reg, div_dvd_reg;
    logic [WIDTH-1:0] xs_prev_reg, xl_prev_reg, xs_cur_reg, xl_cur_reg;
    logic [WIDTH-1:0] acc_s_reg, acc_l_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             swapped_reg, zero_reg;

    logic [WIDTH-1:0] part, diff;
    logic             qbit, swap, zero_in;

    assign zero_in = (operand_a == '0) || (operand_b == '0);
    assign swap    = operand_a > operand_b;
    assign part    = {div_rem_reg, div_dvd_reg[WIDTH-2]};
    assign diff    = part - {1'b0, r_cur_reg};
    assign qbit    = part >= {1'b0, r_cur_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            zero_reg    <= zero_in;
            swapped_reg <= swap;
            if (zero_in)
            begin
                r_prev_reg <= '0;
                r_cur_reg  <= '0;
                xs_cur_reg <= '0;
                xl_cur_reg <= '0;
            end
            else
            begin
                r_prev_reg <= swap ? operand_a : operand_b;
                r_cur_reg  <= swap ? operand_b : operand_a;
                xs_cur_reg <= WIDTH'(1);
                xl_cur_reg <= '0;
            end
            xs_prev_reg <= '0;
            xl_prev_reg <= WIDTH'(1);
        end
        else if (cmd.update)
        begin
            r_prev_reg  <= r_cur_reg;
            r_cur_reg   <= div_rem_reg;
            xs_prev_reg <= xs_cur_reg;
            xl_prev_reg <= xl_cur_reg;
            xs_cur_reg  <= xs_prev_reg - acc_s_reg;
            xl_cur_reg  <= xl_prev_reg - acc_l_reg;
        end

        if (cmd.div_start)
        begin
            div_rem_reg <= '0;
            div_dvd_reg <= r_prev_reg;
            acc_s_reg   <= '0;
            acc_l_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= qbit ? diff[WIDTH-2:0] : part[WIDTH-2:0];
            div_dvd_reg <= {div_dvd_reg[WIDTH-3:0], 1'b0};
            acc_s_reg   <= {acc_s_reg[WIDTH-2:0], 1'b0} + (qbit ? xs_cur_reg : '0);
            acc_l_reg   <= {acc_l_reg[WIDTH-2:0], 1'b0} + (qbit ? xl_cur_reg : '0);
        end
    end

    assign status.zero_op  = zero_reg;
    assign status.div_last = cnt_reg == CNT_W'(DIV_STEPS - 1);
    assign status.rem_zero = div_rem_reg == '0;

    assign coeff_x    = swapped_reg ? xl_cur_reg : xs_cur_reg;
    assign coeff_y    = swapped_reg ? xs_cur_reg : xl_cur_reg;
    assign divisor    = r_cur_reg;
    assign zero_error = zero_reg;

endmodule

// ===== design/bcs_ctrl.sv =====
// Controller of the Bezout coefficient solver: sequences load, divide and update.
// Counts Euclid steps against the iteration bound. Depends on bcs_pkg.
module bcs_ctrl
    import bcs_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    localparam int MAX_STEPS = 2 * WIDTH + 8;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.zero_op || step_reg == STEP_W'(MAX_STEPS))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = status.rem_zero ? S_DONE : S_CHECK;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        busy      = 1'b1;
        done      = 1'b0;
        step_next = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                busy      = 1'b0;
                cmd.load  = start;
                step_next = '0;
            end
            S_CHECK:
            begin
                cmd.div_start = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_EVAL:
            begin
                if (!status.rem_zero)
                begin
                    cmd.update = 1'b1;
                    step_next  = step_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
